// ===== rtl/dep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dep_pkg;

  localparam int NAME_CAP = 16;
  localparam int LEN_W    = $clog2(NAME_CAP + 1);
  localparam int IDX_W    = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SOURCE,
    M_WAIT_ARROW,
    M_RX_ARROW,
    M_DESTINATION,
    M_LINE_DONE
  } mode_t;

  typedef enum logic [2:0] {
    C_NAME,
    C_SPACE,
    C_DASH,
    C_GT,
    C_EOL,
    C_OTHER
  } cls_t;

  typedef enum logic {
    P_PARSE,
    P_EMIT
  } phase_t;

  typedef enum logic [1:0] {
    G_DST,
    G_SPACE,
    G_SRC,
    G_LF
  } seg_t;

  typedef struct packed {
    logic take;
    logic src_start;
    logic src_append;
    logic dst_start;
    logic dst_append;
    logic clr_dst;
    logic clr_both;
    logic emit_start;
    logic emit_run;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic prev_dash;
    logic emit_done;
  } stat_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    if ((c >= "0" && c <= "9") || c == CH_UNDER ||
        (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      k = C_NAME;
    end else if (c == CH_SPACE) begin
      k = C_SPACE;
    end else if (c == CH_DASH) begin
      k = C_DASH;
    end else if (c == CH_GT) begin
      k = C_GT;
    end else if (c == CH_LF || c == CH_CR) begin
      k = C_EOL;
    end else begin
      k = C_OTHER;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dep_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dep_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  dep_pkg::stat_t     stat,
  output dep_pkg::cmd_t      cmd
);
  import dep_pkg::*;

  mode_t  mode_r,  mode_nxt;
  phase_t phase_r, phase_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      phase_r <= P_PARSE;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = (phase_r == P_EMIT);
  assign accept   = in_valid && (phase_r == P_PARSE);

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.take     = accept;
    cmd.emit_run = (phase_r == P_EMIT);

    if (phase_r == P_EMIT && stat.emit_done) begin
      phase_nxt = P_PARSE;
    end

    if (accept) begin
      case (mode_r)
        M_IDLE: begin
          if (stat.cls == C_NAME) begin
            cmd.src_start = 1'b1;
            mode_nxt      = M_SOURCE;
          end
        end
        M_SOURCE: begin
          if (stat.cls == C_NAME) begin
            cmd.src_append = 1'b1;
          end else if (stat.cls == C_SPACE || stat.cls == C_DASH) begin
            mode_nxt = M_WAIT_ARROW;
          end else if (stat.cls == C_GT || stat.cls == C_EOL) begin
            cmd.clr_both = 1'b1;
            mode_nxt     = M_IDLE;
          end
        end
        M_WAIT_ARROW: begin
          if (stat.cls == C_NAME || stat.cls == C_EOL) begin
            cmd.clr_both = 1'b1;
            mode_nxt     = M_IDLE;
          end else if (stat.cls == C_SPACE) begin
            if (stat.prev_dash) begin
              cmd.clr_both = 1'b1;
              mode_nxt     = M_IDLE;
            end
          end else if (stat.cls == C_GT) begin
            if (stat.prev_dash) begin
              cmd.clr_dst = 1'b1;
              mode_nxt    = M_RX_ARROW;
            end else begin
              cmd.clr_both = 1'b1;
              mode_nxt     = M_IDLE;
            end
          end
        end
        M_RX_ARROW: begin
          if (stat.cls == C_NAME) begin
            cmd.dst_start = 1'b1;
            mode_nxt      = M_DESTINATION;
          end else if (stat.cls != C_SPACE) begin
            cmd.clr_both = 1'b1;
            mode_nxt     = M_IDLE;
          end
        end
        M_DESTINATION: begin
          if (stat.cls == C_NAME) begin
            cmd.dst_append = 1'b1;
          end else begin
            // lengths are cleared by the datapath once the line is out
            cmd.emit_start = 1'b1;
            phase_nxt      = P_EMIT;
            mode_nxt       = (stat.cls == C_EOL) ? M_IDLE : M_LINE_DONE;
          end
        end
        M_LINE_DONE: begin
          if (stat.cls == C_EOL) begin
            mode_nxt = M_IDLE;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dep_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dep_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_char_in,
  input  dep_pkg::cmd_t      cmd,
  output dep_pkg::stat_t     stat,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import dep_pkg::*;

  logic [7:0]       src_name_r [NAME_CAP];
  logic [7:0]       dst_name_r [NAME_CAP];
  logic [LEN_W-1:0] src_len_r, src_len_nxt;
  logic [LEN_W-1:0] dst_len_r, dst_len_nxt;
  logic [7:0]       prev_r;
  seg_t             seg_r, seg_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             step;
  logic             emit_done;
  logic             src_wr, dst_wr;
  logic [IDX_W-1:0] src_wa, dst_wa;

  assign stat.cls       = classify(in_char_in);
  assign stat.prev_dash = (prev_r == CH_DASH);
  assign stat.emit_done = emit_done;

  // advance one byte whenever the output register is free or draining
  assign step = cmd.emit_run && (!out_valid_r || !out_stall);

  // name capture; appends beyond the cap are dropped
  always_comb begin
    src_wr = 1'b0;
    dst_wr = 1'b0;
    src_wa = src_len_r[IDX_W-1:0];
    dst_wa = dst_len_r[IDX_W-1:0];
    src_len_nxt = src_len_r;
    dst_len_nxt = dst_len_r;
    if (cmd.src_start) begin
      src_wr      = 1'b1;
      src_wa      = '0;
      src_len_nxt = LEN_W'(1);
    end else if (cmd.src_append && src_len_r < LEN_W'(NAME_CAP)) begin
      src_wr      = 1'b1;
      src_len_nxt = src_len_r + LEN_W'(1);
    end
    if (cmd.dst_start) begin
      dst_wr      = 1'b1;
      dst_wa      = '0;
      dst_len_nxt = LEN_W'(1);
    end else if (cmd.dst_append && dst_len_r < LEN_W'(NAME_CAP)) begin
      dst_wr      = 1'b1;
      dst_len_nxt = dst_len_r + LEN_W'(1);
    end
    if (cmd.clr_dst) begin
      dst_len_nxt = '0;
    end
    if (cmd.clr_both || emit_done) begin
      src_len_nxt = '0;
      dst_len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_wr) begin
      src_name_r[src_wa] <= in_char_in;
    end
    if (dst_wr) begin
      dst_name_r[dst_wa] <= in_char_in;
    end
  end

  // emit sequencer: destination, space, source, LF
  always_comb begin
    seg_nxt       = seg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    emit_done     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.emit_start) begin
      seg_nxt = (dst_len_r != '0) ? G_DST : G_SPACE;
      idx_nxt = '0;
    end else if (step) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      case (seg_r)
        G_DST: begin
          out_byte_nxt = dst_name_r[idx_r[IDX_W-1:0]];
          if (idx_r + LEN_W'(1) == dst_len_r) begin
            seg_nxt = G_SPACE;
          end else begin
            idx_nxt = idx_r + LEN_W'(1);
          end
        end
        G_SPACE: begin
          out_byte_nxt = CH_SPACE;
          idx_nxt      = '0;
          seg_nxt      = (src_len_r != '0) ? G_SRC : G_LF;
        end
        G_SRC: begin
          out_byte_nxt = src_name_r[idx_r[IDX_W-1:0]];
          if (idx_r + LEN_W'(1) == src_len_r) begin
            seg_nxt = G_LF;
          end else begin
            idx_nxt = idx_r + LEN_W'(1);
          end
        end
        G_LF: begin
          out_byte_nxt = CH_LF;
          out_last_nxt = 1'b1;
          emit_done    = 1'b1;
        end
        default: begin
          seg_nxt = G_LF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_len_r   <= '0;
      dst_len_r   <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      seg_r       <= G_DST;
      idx_r       <= '0;
    end else begin
      src_len_r   <= src_len_nxt;
      dst_len_r   <= dst_len_nxt;
      out_valid_r <= out_valid_nxt;
      seg_r       <= seg_nxt;
      idx_r       <= idx_nxt;
      if (cmd.take) begin
        prev_r <= in_char_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/dot_edge_parser.sv =====
// Edge line extractor for "src -> dst" text.
// Input channel: one text byte per transfer on in_char_in (in_valid/in_stall).
// Output channel: bytes of the line "dst src" and LF on out_byte, with
// out_last high on the LF (out_valid/out_stall).
// Throughput: a byte that finishes no edge is taken without stalling. The byte
// that ends a destination name starts the emit sequencer, which puts out
// dst_len + src_len + 2 bytes through the output register, one byte a cycle
// while out_stall is low, with in_stall held high meanwhile. The first output
// byte follows that byte through the phase register and the output register.
// The output register parts the two sides: the last byte of a line may wait
// in it while the next input bytes are taken.
// When the receiver stalls, the output register holds its byte and the emit
// sequencer waits; input stays stalled until the LF has been loaded.
// Reset (rst_n low, synchronous) returns the parser to idle, clears both name
// lengths, the previous byte and the output valid. Name bytes beyond the
// capacity of 16 are dropped.
`timescale 1ns / 1ps
`default_nettype none
module dot_edge_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import dep_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dep_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char_in (in_char_in),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire
